### hdl/wrpc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wrpc_pkg
// Shared constants, types and lane helpers for the weighted random pick
// with per-entry cooldowns.
// ============================================================================
package wrpc_pkg;

    // Entry geometry
    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int WEIGHT_BITS = 8;
    localparam int LANE_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int TIME_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int TABLE_W     = 64;
    localparam int MASK_W      = 8;

    // Weight sum over all entries, and the scaled random value
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int V_W   = SUM_W + FRAC_W;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ENTRIES);
    localparam logic [LANE_W-1:0]  WEIGHT_MASK = LANE_W'((1 << WEIGHT_BITS) - 1);

    // Operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TABLE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TABLE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_MASK = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the request
        logic exec;       // tick or restart, clear the weight sum
        logic idx_clr;    // restart the entry counter
        logic idx_inc;    // advance the entry counter
        logic sum_step;   // add the current entry's weight if eligible
        logic mul;        // scale the random fraction by the weight sum
        logic walk_step;  // subtract the current entry's weight if eligible
        logic emit;       // load the result register, reload the chosen entry
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       n_zero;
        logic       idx_last;
        logic       hit;
        logic       out_free;
    } dp_sts_t;

    // Weight of entry i, limited to WEIGHT_BITS
    function automatic logic [LANE_W-1:0] lane_weight(input logic [TABLE_W-1:0] tbl,
                                                      input logic [IDX_W-1:0] i);
        lane_weight = tbl[LANE_W*i +: LANE_W] & WEIGHT_MASK;
    endfunction

    // Reload time of entry i
    function automatic logic [LANE_W-1:0] lane_cooldown(input logic [TABLE_W-1:0] tbl,
                                                        input logic [IDX_W-1:0] i);
        lane_cooldown = tbl[LANE_W*i +: LANE_W];
    endfunction

endpackage

### hdl/wrpc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// wrpc_ctrl
// Sequencer for the pick: tick or restart, weight sum pass, scale, walk,
// then hand the result to the output register.
// ============================================================================
module wrpc_ctrl
    import wrpc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_MUL,
        ST_WALK,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec    = 1'b1;
                cmd.idx_clr = 1'b1;
                case (sts.op)
                    OP_PICK:    state_next = sts.n_zero ? ST_EMIT : ST_SUM;
                    OP_RESTART: state_next = ST_IDLE;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_MUL;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                // hold the counter on the chosen entry
                if (sts.hit || sts.idx_last) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A captured request is always executed in the next cycle
    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("request not executed after capture");

    // A tick or restart finishes right after its execute cycle
    a_exec_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && (sts.op != OP_PICK) |=> state_reg == ST_IDLE)
        else $error("tick or restart did not return to idle");

    // A finished walk always goes to the result stage
    a_walk_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) && (sts.hit || sts.idx_last) |=> state_reg == ST_EMIT)
        else $error("walk ended without result stage");

endmodule

### hdl/wrpc_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// wrpc_dp
// Datapath: configuration registers, cooldown lanes, weight sum,
// scaled random value, roulette walk and result register.
// ============================================================================
module wrpc_dp
    import wrpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABLE_W-1:0]   cfg_data,
    // request payload
    input  logic [23:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [0:0]           m_tuser,
    // controller link
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts
);

    logic [COUNT_W-1:0] entry_count_reg;
    logic [TABLE_W-1:0] weight_table_reg;
    logic [TABLE_W-1:0] cooldown_table_reg;
    logic [MASK_W-1:0]  connected_mask_reg;

    logic [1:0]         op_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [FRAC_W-1:0]  frac_reg;

    logic [LANE_W-1:0]  cd_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [V_W-1:0]     v_reg;

    logic               out_valid_reg;
    logic               out_picked_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_conn_reg;

    logic [COUNT_W-1:0] n_eff;
    logic [IDX_W-1:0]   n_last;
    logic               n_zero;
    logic [LANE_W-1:0]  cur_w;
    logic               cur_elig;
    logic [V_W-1:0]     cur_w_scaled;
    logic               hit;
    logic               out_free;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg    <= '0;
            weight_table_reg   <= '0;
            cooldown_table_reg <= '0;
            connected_mask_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ENTRY_COUNT:    entry_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_WEIGHT_TABLE:   weight_table_reg   <= cfg_data;
                CFG_COOLDOWN_TABLE: cooldown_table_reg <= cfg_data;
                CFG_CONNECTED_MASK: connected_mask_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the entry count
    assign n_eff  = (entry_count_reg > MAX_COUNT) ? MAX_COUNT : entry_count_reg;
    assign n_zero = (n_eff == '0);
    assign n_last = IDX_W'(n_eff - COUNT_W'(1));

    // Current entry of the sum pass and the walk
    assign cur_w        = lane_weight(weight_table_reg, idx_reg);
    assign cur_elig     = (cd_reg[idx_reg] == '0) && connected_mask_reg[idx_reg];
    assign cur_w_scaled = V_W'({cur_w, {FRAC_W{1'b0}}});
    assign hit          = cur_elig && (v_reg <= cur_w_scaled);

    assign out_free = !out_valid_reg || m_tready;

    assign sts.op       = op_reg;
    assign sts.n_zero   = n_zero;
    assign sts.idx_last = (idx_reg == n_last);
    assign sts.hit      = hit;
    assign sts.out_free = out_free;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_tuser;
            elapsed_reg <= s_tdata[TIME_W-1:0];
            frac_reg    <= s_tdata[TIME_W +: FRAC_W];
        end
    end

    // Cooldown lanes: restart, tick, or reload the chosen entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                cd_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (op_reg == OP_RESTART) begin
                    cd_reg[i] <= lane_cooldown(cooldown_table_reg, IDX_W'(i));
                end else begin
                    cd_reg[i] <= (cd_reg[i] > elapsed_reg) ? cd_reg[i] - elapsed_reg : '0;
                end
            end
        end else if (cmd.emit && !n_zero) begin
            cd_reg[idx_reg] <= lane_cooldown(cooldown_table_reg, idx_reg);
        end
    end

    // Entry counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Weight sum and scaled random value
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            sum_reg <= '0;
        end else if (cmd.sum_step && cur_elig) begin
            sum_reg <= sum_reg + SUM_W'(cur_w);
        end
        if (cmd.mul) begin
            v_reg <= V_W'(frac_reg * sum_reg);
        end else if (cmd.walk_step && cur_elig && !hit) begin
            v_reg <= v_reg - cur_w_scaled;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_picked_reg <= !n_zero;
            out_idx_reg    <= n_zero ? '0 : idx_reg;
            out_conn_reg   <= !n_zero && connected_mask_reg[idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_conn_reg, out_idx_reg};
    assign m_tuser  = out_picked_reg;

    // The chosen entry holds its reload time right after the result
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && !n_zero |=>
        cd_reg[$past(idx_reg)] == $past(lane_cooldown(cooldown_table_reg, idx_reg)))
        else $error("chosen entry not reloaded");

    // The sum pass and the walk never run past the last entry in use
    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step || cmd.sum_step |-> idx_reg <= n_last)
        else $error("entry counter beyond last entry");

    // An empty pick carries an all-zero result
    a_empty_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && n_zero |=> !m_tuser[0] && (m_tdata == 8'h00))
        else $error("empty pick with nonzero result");

endmodule

### hdl/weighted_random_pick_cooldown.sv
`timescale 1ns / 1ps
// ============================================================================
// weighted_random_pick_cooldown
// Weighted roulette pick among connected entries whose cooldown has run out.
// ============================================================================
// Usage:
//   Requests enter on the s_ stream: tuser holds the operation (tick, tick
//   then pick, restart), tdata the elapsed ticks and a 16-bit random fraction.
//   Only a pick request returns one result on the m_ stream: tuser is the
//   picked flag, tdata the chosen index and its connected bit.
//   Registers are written on the cfg_ channel (index, 64-bit data), always
//   ready; write them only while no request is in flight.
// Timing:
//   A tick or restart request runs the execute state and returns to idle.
//   A pick with n entries in use runs execute, the sum pass over the n
//   entries, the scale, a walk of k steps (1 to n) and the result stage;
//   leaving that stage makes the result valid and frees the input. A pick
//   with no entries in use goes from execute straight to the result stage.
//   The sum pass and the walk each go one entry per cycle through one adder
//   and one compare; the scale is one 16x11 multiply.
// Reset:
//   aresetn (synchronous, active low) clears state, config, countdowns and m_tvalid.
// Backpressure:
//   A result waits in the output register while m_tready is low; the next
//   request is accepted meanwhile and a following pick waits only at its end.
// ============================================================================
module weighted_random_pick_cooldown
    import wrpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [7:0] elapsed_time, [23:8] random_fraction
    input  logic [1:0]           s_tuser,   // [1:0] operation
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] chosen_index, [3] chosen_connected, [7:4] zero
    output logic [0:0]           m_tuser,   // [0] picked
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABLE_W-1:0]   cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    wrpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wrpc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/wrpc_pick_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wrpc_pick_checker
// Watches the request, result and register channels of the weighted random
// pick block. Keeps its own copy of the registers and the per-entry
// countdowns, works out the pick that each request causes and compares every
// result taken from the block with the oldest pick still waiting.
// ============================================================================
module wrpc_pick_checker
    import wrpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [7:0] elapsed_time, [23:8] random_fraction
    input  logic [1:0]           s_tuser,   // [1:0] operation
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,   // [2:0] chosen_index, [3] chosen_connected
    input  logic [0:0]           m_tuser,   // [0] picked
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABLE_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct packed {
        logic             picked;
        logic [IDX_W-1:0] index;
        logic             connected;
    } pick_result_t;

    // Register copies and countdowns
    logic [COUNT_W-1:0] entry_count;
    logic [TABLE_W-1:0] weight_tbl;
    logic [TABLE_W-1:0] reload_tbl;
    logic [MASK_W-1:0]  connected_mask;
    logic [LANE_W-1:0]  cooldown_left [MAX_ENTRIES];

    pick_result_t expected_picks [$];

    function automatic logic [LANE_W-1:0] weight_of(input int lane);
        weight_of = weight_tbl[LANE_W*lane +: LANE_W] & WEIGHT_MASK;
    endfunction

    // Entry may be chosen: connected and cooled down
    function automatic logic eligible(input int lane);
        eligible = (cooldown_left[lane] == '0) && connected_mask[lane];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Advance the countdowns for one request and queue the pick it causes
    task automatic apply_request(input logic [1:0] op, input logic [TIME_W-1:0] dt,
                                 input logic [FRAC_W-1:0] frac);
        pick_result_t res;
        int           n;
        int           sel;
        logic         found;
        logic [63:0]  weight_sum;
        logic [63:0]  scaled;
        logic [63:0]  step;

        if (op == OP_RESTART) begin
            for (int lane = 0; lane < MAX_ENTRIES; lane++)
                cooldown_left[lane] = reload_tbl[LANE_W*lane +: LANE_W];
            return;
        end

        for (int lane = 0; lane < MAX_ENTRIES; lane++)
            cooldown_left[lane] = (cooldown_left[lane] > dt) ? cooldown_left[lane] - dt : '0;

        if (op != OP_PICK)
            return;

        n = (entry_count > MAX_COUNT) ? MAX_ENTRIES : int'(entry_count);
        if (n == 0) begin
            res = '0;
            expected_picks.push_back(res);
            return;
        end

        weight_sum = '0;
        for (int lane = 0; lane < n; lane++)
            if (eligible(lane))
                weight_sum += weight_of(lane);

        // Walk the wheel; an entry wins once the scaled value fits its slice
        scaled = 64'(frac) * weight_sum;
        sel    = n;
        found  = 1'b0;
        for (int lane = 0; lane < n; lane++) begin
            if (!found && eligible(lane)) begin
                step = 64'(weight_of(lane)) << FRAC_W;
                if (scaled <= step) begin
                    sel   = lane;
                    found = 1'b1;
                end else begin
                    scaled -= step;
                end
            end
        end
        if (sel > n - 1)
            sel = n - 1;

        cooldown_left[sel] = reload_tbl[LANE_W*sel +: LANE_W];
        res.picked    = 1'b1;
        res.index     = IDX_W'(sel);
        res.connected = connected_mask[sel];
        expected_picks.push_back(res);
    endtask

    // Sample all channels at the rising edge
    always @(posedge aclk) begin
        pick_result_t want;

        if (!aresetn) begin
            entry_count    = '0;
            weight_tbl     = '0;
            reload_tbl     = '0;
            connected_mask = '0;
            for (int lane = 0; lane < MAX_ENTRIES; lane++)
                cooldown_left[lane] = '0;
            expected_picks.delete();
            fail_count = 0;
        end else begin
            // Register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENTRY_COUNT:    entry_count    = cfg_data[COUNT_W-1:0];
                    CFG_WEIGHT_TABLE:   weight_tbl     = cfg_data;
                    CFG_COOLDOWN_TABLE: reload_tbl     = cfg_data;
                    CFG_CONNECTED_MASK: connected_mask = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end

            // Results belong to earlier requests, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("result with no pick pending, index", m_tdata[2:0], -1);
                end else begin
                    want = expected_picks.pop_front();
                    if (m_tuser[0] !== want.picked)
                        report_mismatch("picked", m_tuser[0], want.picked);
                    if (m_tdata[2:0] !== want.index)
                        report_mismatch("chosen_index", m_tdata[2:0], want.index);
                    if (m_tdata[3] !== want.connected)
                        report_mismatch("chosen_connected", m_tdata[3], want.connected);
                end
            end

            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[7:0], s_tdata[23:8]);
        end
        pending_count = expected_picks.size();
    end

endmodule

### tb/weighted_random_pick_cooldown_test.sv
`timescale 1ns / 1ps
// ============================================================================
// weighted_random_pick_cooldown_test
// Drives the weighted random pick block with a directed set of corner
// requests and then phases of random requests under changing register
// settings, with random gaps on both streams, a long result stall and
// drained pauses. The checker beside the block predicts and compares.
// ============================================================================
module weighted_random_pick_cooldown_test;
    import wrpc_pkg::*;

    localparam logic [1:0]           OP_RESERVED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 4'd11;
    localparam int DRAIN_CYCLES  = 32;
    localparam int STALL_CYCLES  = 400;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_GAP       = 18;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // [7:0] elapsed_time, [23:8] random_fraction
    logic [1:0]           s_tuser   = '0;   // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [2:0] chosen_index, [3] chosen_connected
    logic [0:0]           m_tuser;          // [0] picked
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TABLE_W-1:0]   cfg_data  = '0;

    int fail_count;
    int pending_count;
    int hold_off_cycles = 0;
    bit feed_no_gaps    = 1'b0;
    bit sink_no_gaps    = 1'b0;

    weighted_random_pick_cooldown i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wrpc_pick_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop for a hung run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [1:0] op, input logic [TIME_W-1:0] dt,
                                input logic [FRAC_W-1:0] frac);
        int gap;
        gap = feed_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {frac, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop feeding until every pick is back and the block has gone quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Rewrite all registers once the block is idle; junk fills the unused bits
    task automatic configure(input logic [COUNT_W-1:0] count,
                             input logic [TABLE_W-1:0] weights,
                             input logic [TABLE_W-1:0] cooldowns,
                             input logic [MASK_W-1:0]  mask);
        logic [TABLE_W-1:0] junk;
        settle_block();
        junk = {$urandom, $urandom};
        write_reg(CFG_ENTRY_COUNT, {junk[TABLE_W-1:COUNT_W], count});
        write_reg(CFG_WEIGHT_TABLE, weights);
        write_reg(CFG_COOLDOWN_TABLE, cooldowns);
        write_reg(CFG_CONNECTED_MASK, {junk[TABLE_W-1:MASK_W], mask});
        write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Result side: random wait per result, or one long hold-off on request
    initial begin : result_sink
        int wait_cycles;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                wait_cycles     = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (sink_no_gaps) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, MAX_GAP);
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [COUNT_W-1:0]  count;
        logic [TABLE_W-1:0]  weights;
        logic [TABLE_W-1:0]  cooldowns;
        logic [MASK_W-1:0]   mask;
        logic [1:0]          op;
        logic [TIME_W-1:0]   dt;
        logic [FRAC_W-1:0]   frac;
        int                  roll;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset state: no entries, plain tick, reserved operation
        send_request(OP_PICK, 8'hFF, 16'hFFFF);
        send_request(OP_TICK, 8'h00, 16'h0000);
        send_request(OP_RESERVED, 8'hA5, 16'h5AA5);

        // Four full-weight entries without cooldown: lowest, highest, middle fraction
        configure(4'd4, '1, '0, 8'hFF);
        send_request(OP_PICK, 8'h00, 16'h0000);
        send_request(OP_PICK, 8'h00, 16'hFFFF);
        send_request(OP_PICK, 8'h01, 16'h8000);

        // Zero-weight first entry wins only with a zero fraction
        configure(MAX_COUNT, 64'h0706_0504_0302_0100, '0, 8'hFF);
        send_request(OP_PICK, 8'h00, 16'h0000);
        send_request(OP_PICK, 8'h00, 16'h0001);

        // Oversized count, longest cooldowns, half connected; restart leaves
        // nothing eligible so the last entry is the fallback
        configure(4'hF, 64'h8040_2010_0804_0201, '1, 8'h5A);
        send_request(OP_PICK, 8'h00, 16'h1234);
        send_request(OP_PICK, 8'h00, 16'hFEDC);
        send_request(OP_RESTART, 8'h00, 16'h0000);
        send_request(OP_PICK, 8'h00, 16'h4321);
        send_request(OP_TICK, 8'hFF, 16'hFFFF);
        send_request(OP_PICK, 8'hFE, 16'h0000);

        // Nothing connected
        configure(4'd3, '1, 64'h0101_0101_0101_0101, 8'h00);
        send_request(OP_PICK, 8'h00, 16'h7FFF);

        // Single entry
        configure(4'd1, 64'h0000_0000_0000_0033, 64'h0000_0000_0000_0002, 8'h01);
        send_request(OP_PICK, 8'h00, 16'hC000);
        send_request(OP_PICK, 8'h00, 16'hC000);

        // Random phases, each with fresh register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 5)
                0:       count = MAX_COUNT;
                1:       count = 4'd1;
                2:       count = 4'hF;
                default: count = COUNT_W'($urandom_range(0, 15));
            endcase
            case (phase % 4)
                0:       weights = '1;
                1:       weights = {$urandom, $urandom} & 64'h0303_0303_0303_0303;
                default: weights = {$urandom, $urandom};
            endcase
            if (phase % 6 == 5)
                cooldowns = '1;
            else if (phase % 3 == 0)
                cooldowns = {$urandom, $urandom};
            else
                cooldowns = {$urandom, $urandom} & 64'h0F0F_0F0F_0F0F_0F0F;
            mask = (phase % 4 == 2) ? 8'hFF : 8'($urandom);
            configure(count, weights, cooldowns, mask);

            // No-gap feed or sink in some phases, and in one a long result stall with the feed running flat out
            feed_no_gaps = (phase % 4 == 3) || (phase == 2);
            sink_no_gaps = (phase % 5 == 4);
            if (phase == 2)
                hold_off_cycles = STALL_CYCLES;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    op = OP_PICK;
                else if (roll < 85)
                    op = OP_TICK;
                else if (roll < 95)
                    op = OP_RESTART;
                else
                    op = OP_RESERVED;
                dt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                case ($urandom_range(0, 9))
                    0:       frac = '0;
                    1:       frac = '1;
                    default: frac = 16'($urandom);
                endcase
                send_request(op, dt, frac);
                if ($urandom_range(0, 199) == 0)
                    settle_block();
            end
        end

        // Drain and give the verdict
        settle_block();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
